// ===== hdl/switch_debounce_fsm_defines.svh =====
// Assertion macros shared by the switch debouncer's checkers.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef SWITCH_DEBOUNCE_FSM_DEFINES_SVH
`define SWITCH_DEBOUNCE_FSM_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("switch debouncer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("switch debouncer check failed");

// Implication that is also checked while reset is high.
`define SDB_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("switch debouncer check failed");

`endif

// ===== hdl/sdb_pkg.sv =====
// Types, constants and helpers for the switch debouncer.
// Used by the channel interfaces, the state core and the top level.
`default_nettype none

package sdb_pkg;

  // Width and reset value of the settle period register.
  localparam int unsigned PERIOD_W     = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

  // Two-bit state codes as shown on the result channel.
  localparam logic [1:0] CODE_DOWN      = 2'd0;
  localparam logic [1:0] CODE_WAIT_UP   = 2'd1;
  localparam logic [1:0] CODE_UP        = 2'd2;
  localparam logic [1:0] CODE_WAIT_DOWN = 2'd3;

  // Internal one-hot state encoding.
  typedef enum logic [3:0] {
    ST_DOWN      = 4'b0001,
    ST_WAIT_UP   = 4'b0010,
    ST_UP        = 4'b0100,
    ST_WAIT_DOWN = 4'b1000
  } fsm_state_t;

  // One result beat: debounced level and state code after the tick.
  typedef struct packed {
    logic       level;
    logic [1:0] state;
  } result_t;

  // Map the one-hot state onto its external code.
  function automatic logic [1:0] state_code(input fsm_state_t st);
    logic [1:0] code;
    case (st)
      ST_DOWN:      code = CODE_DOWN;
      ST_WAIT_UP:   code = CODE_WAIT_UP;
      ST_UP:        code = CODE_UP;
      ST_WAIT_DOWN: code = CODE_WAIT_DOWN;
      default:      code = CODE_DOWN;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sdb_channels.sv =====
// Valid/ready channel interfaces of the switch debouncer: raw samples,
// debounced results and period writes. Depends on sdb_pkg.
`default_nettype none

interface sdb_sample_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

interface sdb_result_if;
  logic       valid;
  logic       ready;
  logic       debounced_level;
  logic [1:0] fsm_state_out;

  modport source (output valid, output debounced_level, output fsm_state_out, input ready);
  modport sink   (input valid, input debounced_level, input fsm_state_out, output ready);
endinterface

interface sdb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sdb_pkg::PERIOD_W-1:0]  timer_period;

  modport source (output valid, output timer_period, input ready);
  modport sink   (input valid, input timer_period, output ready);
endinterface

`default_nettype wire

// ===== hdl/sdb_core.sv =====
// State core of the switch debouncer: state machine, settle counter,
// pending timeout flag and debounced level. Depends on sdb_pkg.
`default_nettype none

module sdb_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          raw_level,
  input  wire logic [sdb_pkg::PERIOD_W-1:0]  period,
  output sdb_pkg::result_t                   result
);

  sdb_pkg::fsm_state_t              fsm_state;
  sdb_pkg::fsm_state_t              fsm_state_next;
  logic [sdb_pkg::PERIOD_W-1:0]     settle_counter;
  logic [sdb_pkg::PERIOD_W-1:0]     settle_counter_next;
  logic                             timeout_pending;
  logic                             timeout_pending_next;
  logic                             level_reg;
  logic                             level_reg_next;
  logic                             reload;
  logic                             timeout_level;
  logic [sdb_pkg::PERIOD_W-1:0]     count_loaded;

  // Transition and action table. A pending timeout overrides the raw level.
  always_comb begin
    reload         = 1'b0;
    timeout_level  = 1'b0;
    fsm_state_next = fsm_state;
    case (fsm_state)
      sdb_pkg::ST_DOWN: begin
        timeout_level = 1'b0;
        if (timeout_pending) begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_DOWN;
        end else if (raw_level) begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_WAIT_UP;
        end else begin
          fsm_state_next = sdb_pkg::ST_DOWN;
        end
      end
      sdb_pkg::ST_WAIT_UP: begin
        timeout_level = 1'b1;
        if (timeout_pending) begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_UP;
        end else if (raw_level) begin
          fsm_state_next = sdb_pkg::ST_WAIT_UP;
        end else begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_DOWN;
        end
      end
      sdb_pkg::ST_UP: begin
        timeout_level = 1'b1;
        if (timeout_pending) begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_UP;
        end else if (raw_level) begin
          fsm_state_next = sdb_pkg::ST_UP;
        end else begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_WAIT_DOWN;
        end
      end
      sdb_pkg::ST_WAIT_DOWN: begin
        timeout_level = 1'b0;
        if (timeout_pending) begin
          reload         = 1'b1;
          fsm_state_next = sdb_pkg::ST_DOWN;
        end else if (raw_level) begin
          fsm_state_next = sdb_pkg::ST_UP;
        end else begin
          fsm_state_next = sdb_pkg::ST_WAIT_DOWN;
        end
      end
      default: begin
        fsm_state_next = sdb_pkg::ST_DOWN;
      end
    endcase
  end

  // Reload, then count down; reaching zero arms the next timeout.
  always_comb begin
    count_loaded         = reload ? period : settle_counter;
    timeout_pending_next = (count_loaded == sdb_pkg::PERIOD_W'(1));
    if (count_loaded != '0) begin
      settle_counter_next = count_loaded - sdb_pkg::PERIOD_W'(1);
    end else begin
      settle_counter_next = count_loaded;
    end
    level_reg_next = timeout_pending ? timeout_level : level_reg;
  end

  // State registers advance once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state       <= sdb_pkg::ST_DOWN;
      settle_counter  <= sdb_pkg::PERIOD_RESET;
      timeout_pending <= 1'b0;
      level_reg       <= 1'b0;
    end else if (step) begin
      fsm_state       <= fsm_state_next;
      settle_counter  <= settle_counter_next;
      timeout_pending <= timeout_pending_next;
      level_reg       <= level_reg_next;
    end
  end

  // The result of this tick is the state after it.
  assign result.level = level_reg_next;
  assign result.state = sdb_pkg::state_code(fsm_state_next);

endmodule

`default_nettype wire

// ===== hdl/switch_debounce_fsm.sv =====
// Top level of the switch debouncer: period register, state core and the
// result register with skid stage. Depends on sdb_pkg, sdb_channels, sdb_core.
//
// Usage:
//   sample carries one raw switch level per beat; each accepted beat is one
//   tick of the debouncer and gives exactly one beat on result, carrying
//   the debounced level and the state code (0 down, 1 wait-up, 2 up,
//   3 wait-down) after that tick.
//   cfg writes the settle period in ticks (zero disables timeouts); it is
//   always ready and a new period applies at the next counter reload.
//   A result is registered in the output register, or in the skid stage if
//   result stalls; a sample can be taken in every cycle while result drains.
//   The output register is backed by a one-beat skid stage, so a sample is
//   still accepted in the cycle the receiver first stalls; sample.ready
//   falls only once both stages hold a beat.
//   Synchronous reset puts the machine in the down state, level low, the
//   period and the counter at 10 ticks, and empties both result stages.
`default_nettype none

module switch_debounce_fsm (
  input  wire logic     clk,
  input  wire logic     rst,
  sdb_sample_if.sink    sample,
  sdb_result_if.source  result,
  sdb_cfg_if.sink       cfg
);

  logic [sdb_pkg::PERIOD_W-1:0]  timer_period;
  sdb_pkg::result_t              tick_result;
  sdb_pkg::result_t              out_data;
  sdb_pkg::result_t              skid_data;
  logic                          out_valid;
  logic                          skid_valid;
  logic                          accept;

  // Period register; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= sdb_pkg::PERIOD_RESET;
    end else if (cfg.valid) begin
      timer_period <= cfg.timer_period;
    end
  end

  // Samples are taken whenever the skid stage is free.
  assign sample.ready = !skid_valid;
  assign accept       = sample.valid && !skid_valid;

  sdb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .raw_level (sample.raw_level),
    .period    (timer_period),
    .result    (tick_result)
  );

  // Result register and skid stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (result.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : tick_result;
    end else if (accept) begin
      skid_data <= tick_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.debounced_level = out_data.level;
  assign result.fsm_state_out   = out_data.state;

endmodule

`default_nettype wire

// ===== hdl/sdb_checker.sv =====
// Port-level checker for the switch debouncer, bound to its top level.
// Depends on switch_debounce_fsm_defines.svh and the sdb_pkg state codes.
`default_nettype none
`include "switch_debounce_fsm_defines.svh"

module sdb_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       debounced_level,
  input  wire logic [1:0] fsm_state_out
);

  // A stalled result beat keeps its payload.
  `SDB_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(debounced_level) && $stable(fsm_state_out))

  // Level is high exactly in the up and wait-down states.
  `SDB_ASSERT_NOW(a_level_matches_state, clk, rst, out_valid, debounced_level == fsm_state_out[1])

  // With nothing waiting on the output the block must take samples.
  `SDB_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // Reset leaves the result channel empty.
  `SDB_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid && in_ready)

  // An accepted sample always shows a result on the following cycle.
  `SDB_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid)

endmodule

bind switch_debounce_fsm sdb_checker u_sdb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .debounced_level (result.debounced_level),
  .fsm_state_out   (result.fsm_state_out)
);

`default_nettype wire
